[rtl/mwc_pkg.sv]
package mwc_pkg;

  localparam logic [31:0] SEED_Z_BASE = 32'd362436069;
  localparam logic [31:0] SEED_W_BASE = 32'd521288629;
  localparam logic [31:0] SEED_MULT   = 32'd2654435761;
  localparam logic [31:0] Z_MULT      = 32'd36969;
  localparam logic [31:0] W_MULT      = 32'd18000;
  localparam logic [31:0] RANGE_RESET = 32'd20;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic seed_load;
    logic advance;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    div_last;
    logic    out_free;
  } status_t;

endpackage

[rtl/mwc_ctrl.sv]
module mwc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  mwc_pkg::status_t status,
  output mwc_pkg::cmd_t    cmd
);

  mwc_pkg::state_t state;
  mwc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      mwc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = mwc_pkg::ST_EXEC;
        end
      end
      mwc_pkg::ST_EXEC: begin
        if (status.opcode == mwc_pkg::OP_RESEED) begin
          cmd.seed_load = 1'b1;
          state_next    = mwc_pkg::ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = mwc_pkg::ST_DIV_LOAD;
        end
      end
      mwc_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = mwc_pkg::ST_DIV;
      end
      mwc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = mwc_pkg::ST_FINISH;
        end
      end
      mwc_pkg::ST_FINISH: begin
        // hold the result until the output register has room
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mwc_pkg::ST_IDLE;
      end
    endcase
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an unread beat");

  a_exec_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == mwc_pkg::ST_EXEC))
    else $error("accepted beat not executed");

  a_div_done_in_order: assert property (@(posedge clk) disable iff (rst)
    (state == mwc_pkg::ST_DIV && status.div_last) |=> (state == mwc_pkg::ST_FINISH))
    else $error("divider end missed");

endmodule

[rtl/mwc_dp.sv]
module mwc_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tuser,  // [0] opcode
  input  logic [31:0]      s_axis_tdata,  // [31:0] seed
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [31:0] bounded_value, [63:32] raw_word
  input  mwc_pkg::cmd_t    cmd,
  output mwc_pkg::status_t status
);

  mwc_pkg::opcode_t           opcode;
  logic [31:0]                seed;
  logic [31:0]                first_half;
  logic [31:0]                second_half;
  logic [31:0]                range_limit;
  logic [31:0]                rem;
  logic [31:0]                quo;
  logic [mwc_pkg::CNT_W-1:0]  cnt;

  logic [31:0] scrambled;
  logic [31:0] seed_z;
  logic [31:0] seed_w;
  logic [31:0] adv_z;
  logic [31:0] adv_w;
  logic [31:0] raw;
  logic [32:0] trial;
  logic        trial_ge;
  logic [31:0] rem_next;

  assign cfg_ready = 1'b1;

  assign scrambled = seed * mwc_pkg::SEED_MULT;
  assign seed_z    = mwc_pkg::SEED_Z_BASE ^ seed;
  assign seed_w    = mwc_pkg::SEED_W_BASE ^ scrambled;

  assign adv_z = mwc_pkg::Z_MULT * {16'h0000, first_half[15:0]}
               + {16'h0000, first_half[31:16]};
  assign adv_w = mwc_pkg::W_MULT * {16'h0000, second_half[15:0]}
               + {16'h0000, second_half[31:16]};

  assign raw = {first_half[15:0], 16'h0000} + second_half;

  // restoring remainder, one dividend bit per cycle; a zero limit leaves raw
  assign trial    = {rem, quo[31]};
  assign trial_ge = trial >= {1'b0, range_limit};
  assign rem_next = trial_ge ? 32'(trial - {1'b0, range_limit}) : trial[31:0];

  assign status.opcode   = opcode;
  assign status.div_last = (cnt == mwc_pkg::CNT_W'(mwc_pkg::DIV_STEPS - 1));
  assign status.out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= mwc_pkg::RANGE_RESET;
      first_half  <= mwc_pkg::SEED_Z_BASE;
      second_half <= mwc_pkg::SEED_W_BASE;
      cnt         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        range_limit <= cfg_data;
      end
      if (cmd.seed_load) begin
        first_half  <= (seed_z == 32'd0) ? 32'd1 : seed_z;
        second_half <= (seed_w == 32'd0) ? 32'd1 : seed_w;
      end else if (cmd.advance) begin
        first_half  <= adv_z;
        second_half <= adv_w;
      end
      if (cmd.div_load) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      opcode <= mwc_pkg::opcode_t'(s_axis_tuser);
      seed   <= s_axis_tdata;
    end
    if (cmd.div_load) begin
      rem <= '0;
      quo <= raw;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= {quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {raw, rem};
    end
  end

  a_halves_nonzero: assert property (@(posedge clk) disable iff (rst)
    (first_half != 32'd0) && (second_half != 32'd0))
    else $error("generator half stuck at zero");

  a_rem_below_limit: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && range_limit != 32'd0) |-> (rem < range_limit))
    else $error("remainder not below range limit");

  a_result_matches_raw: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (m_axis_tdata[63:32] == $past(raw)))
    else $error("raw word in beat differs from state");

endmodule

[rtl/mwc_random_draw.sv]
// A draw beat passes ST_EXEC, ST_DIV_LOAD, the 32-step restoring remainder in ST_DIV
// and ST_FINISH, then presents its result; a reseed beat passes ST_EXEC and gives none.
// A new beat is accepted only in ST_IDLE, once the last one is through. A result in the
// output register does not block input; the next one waits in ST_FINISH for room.
// Reset (rst, synchronous, active high): generator as seeded with zero, range limit 20,
// no result pending.
module mwc_random_draw (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] seed
  input  logic        s_axis_tuser,  // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [31:0] bounded_value, [63:32] raw_word
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data       // range_limit
);

  mwc_pkg::cmd_t    cmd;
  mwc_pkg::status_t status;

  mwc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  mwc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
